// ===== design/i2c_mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Shared types, phase encoding, command codes and timing helpers for the
// open-drain I2C master bit engine.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

   // Command codes carried in the action field of a request.
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_SEND  = 3'd2;
   localparam logic [2:0] ACT_READ  = 3'd3;
   localparam logic [2:0] ACT_STOP  = 3'd4;

   // Register map: the register index is address bit 2.
   localparam int          CSR_ADDR_W       = 3;
   localparam int          CSR_DATA_W       = 32;
   localparam logic [0:0]  REG_UNIT_TICKS   = 1'b0;
   localparam logic [0:0]  REG_ACK_TIMEOUT  = 1'b1;
   localparam logic [7:0]  UNIT_TICKS_RST   = 8'd10;
   localparam logic [7:0]  ACK_TIMEOUT_RST  = 8'd250;

   // Delay lengths, given as a left shift of one unit (1, 2 or 4 units).
   localparam logic [1:0]  UNITS_1 = 2'd0;
   localparam logic [1:0]  UNITS_2 = 2'd1;
   localparam logic [1:0]  UNITS_4 = 2'd2;

   localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST1     = 5'd1,
      PH_ST2     = 5'd2,
      PH_SP1     = 5'd3,
      PH_SP2     = 5'd4,
      PH_SF1     = 5'd5,
      PH_SF2     = 5'd6,
      PH_TX_LOW  = 5'd7,
      PH_TX_HIGH = 5'd8,
      PH_TX_GAP  = 5'd9,
      PH_AK_REL  = 5'd10,
      PH_AK_HIGH = 5'd11,
      PH_POLL    = 5'd12,
      PH_RX_LOW  = 5'd13,
      PH_RX_HIGH = 5'd14,
      PH_RA_LOW  = 5'd15,
      PH_RA_HIGH = 5'd16
   } phase_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       give_ack;
      logic       sda_sample;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } rsp_type;

   // Length of a wait in ticks; a zero unit counts as one tick.
   function automatic logic [9:0] wait_ticks(input logic [1:0] units,
                                             input logic [7:0] unit);
      logic [9:0] unit_eff;
      unit_eff = (unit == 8'd0) ? 10'd1 : {2'b00, unit};
      return unit_eff << units;
   endfunction

endpackage

// ===== design/i2c_master_bit_engine_core.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Open-drain I2C master that steps its bus timing once per request
// transaction and returns the resulting line levels and status.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake          | contents
//   ----------+-----------+--------------------+-------------------------------
//   req_      | in        | req_valid/req_stall| command, byte, ack choice, SDA
//   rsp_      | out       | rsp_valid/rsp_stall| SCL, SDA drive, status, rx byte
//   csr_      | in/out    | APB, pready high   | unit_ticks, ack_timeout
//
// Every request transaction is one bus tick and produces exactly one response
// transaction in the next cycle. The engine takes one request per clock cycle
// while it is not stalled; the whole state update is a single pass through the
// phase logic into the state and response registers. Reset is synchronous and
// returns the bus to idle with both lines released. When the response register
// is full and the downstream side stalls, req_stall is raised and the state
// holds until the pending response has been taken.
//
module i2c_master_bit_engine_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  i2c_mbe_pkg::req_type                  req_data,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output i2c_mbe_pkg::rsp_type                  rsp_data,
   // Configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [i2c_mbe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [i2c_mbe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [i2c_mbe_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                  csr_pready
);
   import i2c_mbe_pkg::*;

   // Configuration registers.
   logic [7:0] unit_ticks_ff;
   logic [7:0] ack_timeout_ff;

   // Engine state.
   phase_type  phase_ff,     phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [9:0] timer_ff,     timer_in;
   logic [7:0] shift_ff,     shift_in;
   logic [7:0] wait_ff,      wait_in;
   logic       scl_ff,       scl_in;
   logic       sda_low_ff,   sda_low_in;
   logic [7:0] rx_byte_ff,   rx_byte_in;
   logic       failed_ff,    failed_in;
   logic       ack_latch_ff, ack_latch_in;
   logic       done_in;

   // Response register.
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff,  rsp_data_in;

   logic       req_fire;
   logic       csr_write;
   logic [9:0] timer_dec;
   logic       expired;

   // ------------------------------------------------------------------------
   // Configuration port. The register index sits in address bit 2; the low
   // address bits select a byte lane and are not decoded.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff  <= UNIT_TICKS_RST;
         ack_timeout_ff <= ACK_TIMEOUT_RST;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_UNIT_TICKS:  unit_ticks_ff  <= csr_pwdata[7:0];
            REG_ACK_TIMEOUT: ack_timeout_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_UNIT_TICKS:  csr_prdata = {{(CSR_DATA_W-8){1'b0}}, unit_ticks_ff};
         REG_ACK_TIMEOUT: csr_prdata = {{(CSR_DATA_W-8){1'b0}}, ack_timeout_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Handshake. A request is taken whenever the response register is empty or is
   // being emptied this cycle; unless stalled, the engine runs one tick per clock.
   // ------------------------------------------------------------------------
   assign req_stall    = rsp_valid_ff && rsp_stall;
   assign req_fire     = req_valid && !req_stall;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && rsp_stall);

   // The delay timer counts down before the phase logic looks at it, so the
   // next line action falls on the tick on which the wait runs out.
   assign timer_dec = (timer_ff != 10'd0) ? (timer_ff - 10'd1) : timer_ff;
   assign expired   = (timer_dec == 10'd0);

   // ------------------------------------------------------------------------
   // Phase logic: next state for one bus tick.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      timer_in     = timer_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      scl_in       = scl_ff;
      sda_low_in   = sda_low_ff;
      rx_byte_in   = rx_byte_ff;
      failed_in    = failed_ff;
      ack_latch_in = ack_latch_ff;
      done_in      = 1'b0;

      if (phase_ff == PH_IDLE) begin
         // A command is only taken while idle; unknown codes are plain ticks.
         case (req_data.action)
            ACT_START: begin
               scl_in     = 1'b1;
               sda_low_in = 1'b0;
               timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
               phase_in   = PH_ST1;
            end
            ACT_SEND: begin
               bit_count_in = 4'd0;
               scl_in       = 1'b0;
               sda_low_in   = ~req_data.tx_byte[7];
               shift_in     = {req_data.tx_byte[6:0], 1'b0};
               timer_in     = wait_ticks(UNITS_2, unit_ticks_ff);
               phase_in     = PH_TX_LOW;
            end
            ACT_READ: begin
               ack_latch_in = req_data.give_ack;
               shift_in     = 8'd0;
               bit_count_in = 4'd0;
               scl_in       = 1'b0;
               sda_low_in   = 1'b0;
               timer_in     = wait_ticks(UNITS_2, unit_ticks_ff);
               phase_in     = PH_RX_LOW;
            end
            ACT_STOP: begin
               scl_in     = 1'b0;
               sda_low_in = 1'b1;
               timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
               phase_in   = PH_SP1;
            end
            default: ;
         endcase
      end else if (phase_ff == PH_POLL) begin
         // Acknowledge poll: SDA low ends the send, otherwise count to timeout.
         if (!req_data.sda_sample) begin
            scl_in     = 1'b0;
            sda_low_in = 1'b0;
            failed_in  = 1'b0;
            phase_in   = PH_IDLE;
            done_in    = 1'b1;
         end else if (wait_ff >= ack_timeout_ff) begin
            scl_in     = 1'b0;
            sda_low_in = 1'b1;
            timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
            phase_in   = PH_SF1;
         end else begin
            wait_in = wait_ff + 8'd1;
         end
      end else begin
         timer_in = timer_dec;
         if (expired) begin
            unique case (phase_ff)
               PH_ST1: begin
                  scl_in     = 1'b1;
                  sda_low_in = 1'b1;
                  timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
                  phase_in   = PH_ST2;
               end
               PH_ST2: begin
                  scl_in     = 1'b0;
                  sda_low_in = 1'b1;
                  phase_in   = PH_IDLE;
                  done_in    = 1'b1;
               end
               PH_SP1: begin
                  scl_in     = 1'b1;
                  sda_low_in = 1'b0;
                  timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
                  phase_in   = PH_SP2;
               end
               PH_SF1: begin
                  scl_in     = 1'b1;
                  sda_low_in = 1'b0;
                  timer_in   = wait_ticks(UNITS_4, unit_ticks_ff);
                  phase_in   = PH_SF2;
               end
               PH_SF2: begin
                  failed_in = 1'b1;
                  phase_in  = PH_IDLE;
                  done_in   = 1'b1;
               end
               PH_TX_LOW: begin
                  scl_in   = 1'b1;
                  timer_in = wait_ticks(UNITS_2, unit_ticks_ff);
                  phase_in = PH_TX_HIGH;
               end
               PH_TX_HIGH: begin
                  scl_in   = 1'b0;
                  timer_in = wait_ticks(UNITS_2, unit_ticks_ff);
                  phase_in = PH_TX_GAP;
               end
               PH_TX_GAP: begin
                  bit_count_in = bit_count_ff + 4'd1;
                  if (bit_count_in < BITS_PER_BYTE) begin
                     scl_in     = 1'b0;
                     sda_low_in = ~shift_ff[7];
                     shift_in   = {shift_ff[6:0], 1'b0};
                     timer_in   = wait_ticks(UNITS_2, unit_ticks_ff);
                     phase_in   = PH_TX_LOW;
                  end else begin
                     scl_in     = 1'b0;
                     sda_low_in = 1'b0;
                     timer_in   = wait_ticks(UNITS_1, unit_ticks_ff);
                     phase_in   = PH_AK_REL;
                  end
               end
               PH_AK_REL: begin
                  scl_in     = 1'b1;
                  sda_low_in = 1'b0;
                  timer_in   = wait_ticks(UNITS_1, unit_ticks_ff);
                  phase_in   = PH_AK_HIGH;
               end
               PH_AK_HIGH: begin
                  wait_in  = 8'd0;
                  phase_in = PH_POLL;
               end
               PH_RX_LOW: begin
                  scl_in       = 1'b1;
                  sda_low_in   = 1'b0;
                  shift_in     = {shift_ff[6:0], req_data.sda_sample};
                  bit_count_in = bit_count_ff + 4'd1;
                  timer_in     = wait_ticks(UNITS_1, unit_ticks_ff);
                  phase_in     = PH_RX_HIGH;
               end
               PH_RX_HIGH: begin
                  scl_in   = 1'b0;
                  timer_in = wait_ticks(UNITS_2, unit_ticks_ff);
                  if (bit_count_ff < BITS_PER_BYTE) begin
                     sda_low_in = 1'b0;
                     phase_in   = PH_RX_LOW;
                  end else begin
                     sda_low_in = ack_latch_ff;
                     phase_in   = PH_RA_LOW;
                  end
               end
               PH_RA_LOW: begin
                  scl_in   = 1'b1;
                  timer_in = wait_ticks(UNITS_2, unit_ticks_ff);
                  phase_in = PH_RA_HIGH;
               end
               PH_RA_HIGH: begin
                  scl_in     = 1'b0;
                  rx_byte_in = shift_ff;
                  phase_in   = PH_IDLE;
                  done_in    = 1'b1;
               end
               default: begin
                  // End of the stop condition, and recovery from any stray code.
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            endcase
         end
      end
   end

   // The response carries the line and status state as it stands after this
   // tick, which is exactly what the state registers take on.
   always_comb begin
      rsp_data_in.scl_level    = scl_in;
      rsp_data_in.sda_pull_low = sda_low_in;
      rsp_data_in.busy_res     = (phase_in != PH_IDLE);
      rsp_data_in.done_res     = done_in;
      rsp_data_in.rx_byte      = rx_byte_in;
      rsp_data_in.ack_failed   = failed_in;
   end

   // ------------------------------------------------------------------------
   // State registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= 4'd0;
         timer_ff     <= 10'd0;
         shift_ff     <= 8'd0;
         wait_ff      <= 8'd0;
         scl_ff       <= 1'b1;
         sda_low_ff   <= 1'b0;
         rx_byte_ff   <= 8'd0;
         failed_ff    <= 1'b0;
         ack_latch_ff <= 1'b0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         timer_ff     <= timer_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         scl_ff       <= scl_in;
         sda_low_ff   <= sda_low_in;
         rx_byte_ff   <= rx_byte_in;
         failed_ff    <= failed_in;
         ack_latch_ff <= ack_latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // Every accepted tick leaves a response in the output register.
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted tick produced no response");

   // The busy flag of the pending response agrees with the phase register.
   a_busy_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.busy_res == (phase_ff != PH_IDLE)))
      else $error("busy flag disagrees with engine phase");

   // A completion pulse is only reported with the engine back at idle.
   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_res) |-> !rsp_data_ff.busy_res)
      else $error("completion reported while still busy");

   // The bit counter never runs past one byte.
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BITS_PER_BYTE)
      else $error("bit counter beyond one byte");

endmodule
